>>> rtl/core/sue_pkg.sv
// Shared types and constants for the batch echo UART.
// No dependencies; sue_cfg, sue_core and soft_uart_batch_echo import this package.
`timescale 1ns / 1ps

package sue_pkg;

	// Default depth of the byte buffer.
	localparam int unsigned BUF_DEPTH_DEF = 16;

	// Register reset values.
	localparam logic [8:0] BIT_PERIOD_RST = 9'd99;
	localparam logic [4:0] BATCH_LEN_RST  = 5'd16;

	// APB address and data widths.
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_BIT_PERIOD = 1'b0,
		REG_BATCH_LEN  = 1'b1
	} reg_idx_t;

	// Frame state, one-hot.
	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_RECV = 3'b010,
		MODE_SEND = 3'b100
	} mode_t;

	typedef struct packed {
		logic [8:0] bit_period;
		logic [4:0] batch_length;
	} cfg_t;

	typedef struct packed {
		logic       tx_line;
		logic       byte_done;
		logic [7:0] received_byte;
		logic       echoing;
	} result_t;

endpackage

>>> rtl/core/sue_if.sv
// Handshake channels of the batch echo UART: tick input and per-tick result.
// No dependencies.
`timescale 1ns / 1ps

interface sue_rx_if;
	logic valid;
	logic ready;
	logic rx_line;

	modport source (output valid, output rx_line, input ready);
	modport sink (input valid, input rx_line, output ready);
endinterface

interface sue_res_if;
	logic       valid;
	logic       ready;
	logic       tx_line;
	logic       byte_done;
	logic [7:0] received_byte;
	logic       echoing;

	modport source (output valid, output tx_line, output byte_done,
		output received_byte, output echoing, input ready);
	modport sink (input valid, input tx_line, input byte_done,
		input received_byte, input echoing, output ready);
endinterface

>>> rtl/core/soft_uart_batch_echo.sv
// Top level of the batch echo UART: channels, APB registers, core and buffer.
// Depends on sue_pkg, sue_if, sue_cfg, sue_buf and sue_core.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one transaction per prescaler tick, carrying the sampled rx_line.
//   out_ch : exactly one transaction per input tick, in order: tx_line level
//            after the tick, byte_done/received_byte for a completed receive
//            frame, and echoing while the held batch is sent back.
//   APB    : bit_period at 0x0, batch_length at 0x4; write only while idle.
// Result: a tick's result is registered and presented in the cycle after it is accepted.
// Throughput: one tick per clock while results are taken. The whole tick update (timer, frame
//   counter, shift, buffer write, fill/send bookkeeping) is one pass of
//   logic into the state registers; the echo byte comes from a registered
//   buffer read fetched on the tick before it is needed.
// Stall: a held result blocks in_ch only while out_ch.ready is low;
//   the result register frees in the same cycle it is taken.
// Reset: arst_n clears the frame state to idle, the line high, the fill
//   count to zero and the registers to 99 and 16. Buffer contents are not
//   cleared; only written entries are ever sent.
module soft_uart_batch_echo #(
	parameter int unsigned BUFFER_DEPTH = sue_pkg::BUF_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sue_rx_if.sink                     in_ch,
	sue_res_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sue_pkg::APB_AW-1:0] paddr,
	input  logic [sue_pkg::APB_DW-1:0] pwdata,
	output logic [sue_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import sue_pkg::*;

	localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(BUFFER_DEPTH + 1);

	cfg_t              cfg;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;
	logic              step;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	// Take a tick whenever the result register is empty or being drained.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign step        = in_ch.valid && in_ch.ready;

	sue_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sue_core #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.ADDR_W       (ADDR_W),
		.FILL_W       (FILL_W)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_line (in_ch.rx_line),
		.cfg     (cfg),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.res     (res)
	);

	// Buffer updates and fetches advance only with accepted ticks.
	sue_buf #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.ADDR_W       (ADDR_W)
	) u_buf (
		.clk     (clk),
		.en      (step),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register: hold while stalled, load on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.tx_line       = res_q.tx_line;
	assign out_ch.byte_done     = res_q.byte_done;
	assign out_ch.received_byte = res_q.received_byte;
	assign out_ch.echoing       = res_q.echoing;

endmodule

>>> rtl/core/sue_cfg.sv
// APB register file: bit period and batch length.
// Depends on sue_pkg.
`timescale 1ns / 1ps

module sue_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sue_pkg::APB_AW-1:0] paddr,
	input  logic [sue_pkg::APB_DW-1:0] pwdata,
	output logic [sue_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output sue_pkg::cfg_t              cfg
);
	import sue_pkg::*;

	logic [8:0] bit_period_q;
	logic [4:0] batch_length_q;
	reg_idx_t   idx;
	logic       wr;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q   <= BIT_PERIOD_RST;
			batch_length_q <= BATCH_LEN_RST;
		end else if (wr) begin
			unique case (idx)
				REG_BIT_PERIOD: bit_period_q   <= pwdata[8:0];
				REG_BATCH_LEN:  batch_length_q <= pwdata[4:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BIT_PERIOD: prdata = {{(APB_DW-9){1'b0}}, bit_period_q};
			REG_BATCH_LEN:  prdata = {{(APB_DW-5){1'b0}}, batch_length_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.bit_period   = bit_period_q;
	assign cfg.batch_length = batch_length_q;

endmodule

>>> rtl/core/sue_buf.sv
// Byte buffer: one write port, one read port with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module sue_buf #(
	parameter int unsigned BUFFER_DEPTH = 16,
	parameter int unsigned ADDR_W       = 4
) (
	input  logic              clk,
	input  logic              en,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);
	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (en && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Forward a same-cycle write so the fetch sees the newest byte.
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/core/sue_core.sv
// Per-tick UART state machine: receive framing, batch fill and echo transmit.
// Depends on sue_pkg; drives the sue_buf ports.
`timescale 1ns / 1ps

module sue_core #(
	parameter int unsigned BUFFER_DEPTH = sue_pkg::BUF_DEPTH_DEF,
	parameter int unsigned ADDR_W       = 4,
	parameter int unsigned FILL_W       = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 rx_line,
	input  sue_pkg::cfg_t        cfg,
	input  logic [7:0]           rd_data,
	output logic                 wr_en,
	output logic [ADDR_W-1:0]    wr_addr,
	output logic [7:0]           wr_data,
	output logic [ADDR_W-1:0]    rd_addr,
	output sue_pkg::result_t     res
);
	import sue_pkg::*;

	mode_t             mode_q, mode_n;
	logic [7:0]        tick_q, tick_n;
	logic [3:0]        bit_q, bit_n;
	logic [7:0]        shift_q, shift_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [FILL_W-1:0] send_q, send_n;
	logic              line_q, line_n;

	logic [7:0]        period_lim;
	logic [FILL_W-1:0] batch_eff;
	logic              boundary;
	logic [3:0]        bit_inc;
	logic [FILL_W-1:0] fill_inc;
	logic [FILL_W-1:0] send_inc;
	logic              done;
	logic [7:0]        got;

	// Clamp registers: period 0 acts as 1, above 256 as 256; batch into 1..depth.
	always_comb begin
		if (cfg.bit_period == 9'd0) begin
			period_lim = 8'd0;
		end else if (cfg.bit_period > 9'd256) begin
			period_lim = 8'hFF;
		end else begin
			period_lim = 8'(cfg.bit_period - 9'd1);
		end
		if (cfg.batch_length == 5'd0) begin
			batch_eff = FILL_W'(1);
		end else if (int'(cfg.batch_length) > BUFFER_DEPTH) begin
			batch_eff = FILL_W'(BUFFER_DEPTH);
		end else begin
			batch_eff = FILL_W'(cfg.batch_length);
		end
	end

	assign boundary = (tick_q >= period_lim);
	assign bit_inc  = bit_q + 4'd1;
	assign fill_inc = fill_q + FILL_W'(1);
	assign send_inc = send_q + FILL_W'(1);

	always_comb begin
		mode_n  = mode_q;
		tick_n  = tick_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		fill_n  = fill_q;
		send_n  = send_q;
		line_n  = line_q;
		done    = 1'b0;
		got     = 8'd0;
		wr_en   = 1'b0;
		unique case (mode_q)
			MODE_RECV: begin
				if (!boundary) begin
					tick_n = tick_q + 8'd1;
				end else begin
					tick_n = 8'd0;
					if (bit_q < 4'd8) begin
						shift_n = shift_q | (8'(rx_line) << bit_q[2:0]);
						bit_n   = bit_inc;
					end else if (bit_q == 4'd8) begin
						bit_n = bit_inc;
					end else begin
						done   = 1'b1;
						got    = shift_q;
						bit_n  = 4'd0;
						mode_n = MODE_IDLE;
						if (fill_q < FILL_W'(BUFFER_DEPTH)) begin
							wr_en  = 1'b1;
							fill_n = fill_inc;
						end
						if (fill_n >= batch_eff) begin
							mode_n = MODE_SEND;
							send_n = '0;
							line_n = 1'b0;
						end
					end
				end
			end
			MODE_SEND: begin
				if (!boundary) begin
					tick_n = tick_q + 8'd1;
				end else begin
					tick_n = 8'd0;
					if (bit_q < 4'd8) begin
						line_n = rd_data[bit_q[2:0]];
						bit_n  = bit_inc;
					end else if (bit_q == 4'd8) begin
						line_n = 1'b1;
						bit_n  = bit_inc;
					end else if (send_inc >= fill_q) begin
						mode_n = MODE_IDLE;
						fill_n = '0;
						send_n = '0;
						bit_n  = 4'd0;
						line_n = 1'b1;
					end else begin
						send_n = send_inc;
						bit_n  = 4'd0;
						line_n = 1'b0;
					end
				end
			end
			default: begin
				// Idle, and any stray code, looks for a start bit.
				mode_n = MODE_IDLE;
				if (!rx_line) begin
					mode_n  = MODE_RECV;
					tick_n  = 8'd0;
					bit_n   = 4'd0;
					shift_n = 8'd0;
				end
			end
		endcase
	end

	assign wr_addr = fill_q[ADDR_W-1:0];
	assign wr_data = shift_q;
	assign rd_addr = send_n[ADDR_W-1:0];

	assign res.tx_line       = line_n;
	assign res.byte_done     = done;
	assign res.received_byte = got;
	assign res.echoing       = (mode_n == MODE_SEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			tick_q  <= 8'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			fill_q  <= '0;
			send_q  <= '0;
			line_q  <= 1'b1;
		end else if (step) begin
			mode_q  <= mode_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			fill_q  <= fill_n;
			send_q  <= send_n;
			line_q  <= line_n;
		end
	end

`ifndef ASSERT_OFF
	a_send_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SEND) |-> (fill_q != '0) && (send_q < fill_q))
		else $error("send index outside held bytes");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(BUFFER_DEPTH))
		else $error("fill count beyond buffer depth");
	a_bit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'd9)
		else $error("bit index beyond frame");
	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_SEND) |-> line_q)
		else $error("tx line low outside echo");
	a_start_bit_low: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SEND) && (bit_q == 4'd0) |-> !line_q)
		else $error("start bit not driven low");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for soft_uart_batch_echo: a per-tick line model
// drives valid/ready channels and an APB port. Depends on sue_pkg, sue_if
// and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import sue_pkg::*;

	localparam int DEPTH = BUF_DEPTH_DEF;
	// Cycle budget for the whole run, far above the slowest legal run.
	localparam int LIMIT = 600000;
	// Cycles to let pass after the last result before touching registers.
	localparam int SETTLE = 3;

	localparam result_t IDLE_RES = '{1'b1, 1'b0, 8'h00, 1'b0};

	// One directed stimulus row: hold rx for reps ticks. Where typed is set,
	// the result of every tick in the row is the one given here.
	typedef struct packed {
		logic       rx;
		logic [7:0] reps;
		logic       typed;
		result_t    want;
	} row_t;

	// One random phase: register values to write, then a budget of ticks
	// that the line logic actually looks at.
	typedef struct packed {
		logic [8:0]  period;
		logic [4:0]  batch;
		logic [15:0] budget;
	} phase_t;

	// Directed part, run with one tick per bit and a batch of two bytes.
	localparam row_t DIRECTED [0:10] = '{
		'{1'b1, 8'd3,  1'b1, IDLE_RES},                   // line idle after reset
		'{1'b0, 8'd1,  1'b1, IDLE_RES},                   // start bit detected
		'{1'b1, 8'd8,  1'b0, IDLE_RES},                   // data bits all high
		'{1'b1, 8'd1,  1'b0, IDLE_RES},                   // period after last sample
		'{1'b1, 8'd1,  1'b1, '{1'b1, 1'b1, 8'hFF, 1'b0}}, // byte 0xFF, batch not full
		'{1'b0, 8'd1,  1'b1, IDLE_RES},                   // new start right after
		'{1'b0, 8'd8,  1'b0, IDLE_RES},                   // data bits all low
		'{1'b0, 8'd1,  1'b0, IDLE_RES},                   // low line in stop time
		'{1'b0, 8'd1,  1'b1, '{1'b0, 1'b1, 8'h00, 1'b1}}, // batch full: echo starts
		'{1'b0, 8'd20, 1'b0, IDLE_RES},                   // echo of two bytes
		'{1'b1, 8'd2,  1'b1, IDLE_RES}                    // back to idle
	};

	// Random phases: extremes, out-of-range values and a few plain settings.
	// Bytes left in the buffer at the end of a phase carry into the next one.
	localparam phase_t PHASES [0:8] = '{
		'{9'd1,   5'd1,  16'd20},
		'{9'd2,   5'd2,  16'd12},
		'{9'd0,   5'd0,  16'd12},
		'{9'd1,   5'd31, 16'd50},
		'{9'd1,   5'd3,  16'd12},
		'{9'd3,   5'd1,  16'd10},
		'{9'd1,   5'd17, 16'd34},
		'{9'd1,   5'd1,  16'd12},
		'{9'd5,   5'd4,  16'd10}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	sue_rx_if  in_ch ();
	sue_res_if out_ch ();

	soft_uart_batch_echo DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the registers as the block should hold them.
	cfg_t cfg_shadow;

	// Line model state: frame mode, tick timer within a bit, periods elapsed
	// in the frame, receive shift register, byte buffer, bytes held, bytes
	// already echoed and the transmit level.
	mode_t      p_mode;
	logic [7:0] p_timer;
	logic [3:0] p_slot;
	logic [7:0] p_shift;
	logic [7:0] p_buf [DEPTH];
	logic [4:0] p_held;
	logic [4:0] p_sent;
	logic       p_txd;

	result_t tick_results_q [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          sampled_ticks;
	int          mismatch_count;
	int          cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Bit period as the block applies it: zero acts as one, above 256 as 256.
	function automatic logic [8:0] ticks_per_bit();
		if (cfg_shadow.bit_period == 9'd0)
			return 9'd1;
		if (cfg_shadow.bit_period > 9'd256)
			return 9'd256;
		return cfg_shadow.bit_period;
	endfunction

	// Advance the line model by one tick. sig is set when the tick's rx level
	// can matter: idle start detection or a bit boundary while receiving.
	task automatic advance_uart(input logic rx, output result_t res, output bit sig);
		logic       done;
		logic [7:0] got;
		logic [8:0] per;
		logic [4:0] bat;
		logic       fire;
		logic [3:0] nxt;
		logic [3:0] pos;
		logic [7:0] cur;
		done = 1'b0;
		got  = 8'h00;
		sig  = 1'b0;
		per  = ticks_per_bit();
		if (cfg_shadow.batch_length == 5'd0)
			bat = 5'd1;
		else if (cfg_shadow.batch_length > DEPTH)
			bat = 5'(DEPTH);
		else
			bat = cfg_shadow.batch_length;
		fire = ({1'b0, p_timer} >= per - 9'd1);
		case (p_mode)
			MODE_RECV: begin
				p_timer = fire ? 8'd0 : p_timer + 8'd1;
				sig = fire;
				if (fire) begin
					if (p_slot < 4'd8) begin
						if (rx)
							p_shift[p_slot[2:0]] = 1'b1;
						p_slot = p_slot + 4'd1;
					end else if (p_slot == 4'd8) begin
						p_slot = 4'd9;
					end else begin
						// Tenth boundary: the byte is complete.
						got     = p_shift;
						done    = 1'b1;
						p_slot  = 4'd0;
						p_timer = 8'd0;
						p_mode  = MODE_IDLE;
						if (p_held < DEPTH) begin
							p_buf[p_held[3:0]] = got;
							p_held = p_held + 5'd1;
						end
						if (p_held >= bat) begin
							// Batch full: first echoed start bit goes out now.
							p_mode = MODE_SEND;
							p_sent = 5'd0;
							p_txd  = 1'b0;
						end
					end
				end
			end
			MODE_SEND: begin
				p_timer = fire ? 8'd0 : p_timer + 8'd1;
				if (fire) begin
					nxt = p_slot + 4'd1;
					cur = p_buf[p_sent[3:0]];
					if (nxt <= 4'd8) begin
						pos    = nxt - 4'd1;
						p_txd  = cur[pos[2:0]];
						p_slot = nxt;
					end else if (nxt == 4'd9) begin
						p_txd  = 1'b1;
						p_slot = nxt;
					end else begin
						p_sent = p_sent + 5'd1;
						if (p_sent >= p_held) begin
							p_mode = MODE_IDLE;
							p_held = 5'd0;
							p_sent = 5'd0;
							p_txd  = 1'b1;
						end else begin
							p_txd = 1'b0;
						end
						p_slot  = 4'd0;
						p_timer = 8'd0;
					end
				end
			end
			default: begin
				sig    = 1'b1;
				p_mode = MODE_IDLE;
				if (!rx) begin
					p_mode  = MODE_RECV;
					p_timer = 8'd0;
					p_slot  = 4'd0;
					p_shift = 8'h00;
				end
			end
		endcase
		res.tx_line       = p_txd;
		res.byte_done     = done;
		res.received_byte = got;
		res.echoing       = (p_mode == MODE_SEND);
	endtask

	// Offer one tick, wait for its transaction, then queue what it should yield.
	task automatic drive_tick(input logic rx, input logic typed = 1'b0,
		input result_t want = IDLE_RES);
		result_t pred;
		bit      sig;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_line <= rx;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		advance_uart(rx, pred, sig);
		sampled_ticks += sig;
		tick_results_q.push_back(typed ? want : pred);
	endtask

	// APB write: setup cycle, access cycle, then back to idle.
	task automatic write_reg(input reg_idx_t idx, input logic [8:0] value);
		logic [APB_DW-1:0] word;
		word = $urandom;
		if (idx == REG_BIT_PERIOD)
			word[8:0] = value;
		else
			word[4:0] = value[4:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (idx == REG_BIT_PERIOD)
			cfg_shadow.bit_period = word[8:0];
		else
			cfg_shadow.batch_length = word[4:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB read, compared against the register shadow.
	task automatic check_reg(input reg_idx_t idx);
		logic [8:0] seen;
		logic [8:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (idx == REG_BIT_PERIOD) begin
			seen = prdata[8:0];
			want = cfg_shadow.bit_period;
		end else begin
			seen = {4'd0, prdata[4:0]};
			want = {4'd0, cfg_shadow.batch_length};
		end
		if (seen !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t register %s readback: expected %0d, actual %0d",
					$time, idx.name(), want, seen);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [8:0] period, input logic [4:0] batch);
		write_reg(REG_BIT_PERIOD, period);
		check_reg(REG_BIT_PERIOD);
		write_reg(REG_BATCH_LEN, {4'd0, batch});
		check_reg(REG_BATCH_LEN);
	endtask

	// One 8N1 frame at the current bit period, start bit first. The start bit
	// is detected on its first tick, so each later bit is sampled on its first
	// tick too. trail adds one high tick so the next start is not swallowed by
	// the tick that completes the byte.
	task automatic send_frame(input logic [7:0] data, input logic stop, input bit trail);
		int   per;
		logic lvl;
		per = int'(ticks_per_bit());
		for (int s = 0; s < 10; s++) begin
			lvl = (s == 0) ? 1'b0 : (s == 9) ? stop : data[s - 1];
			repeat (per)
				drive_tick(lvl);
		end
		if (trail)
			drive_tick(1'b1);
	endtask

	// Mostly clean frames with random data, mixed with idle gaps, line noise
	// and broken frames. Ticks during an echo are ignored, so do not count.
	task automatic run_phase(input int budget);
		int          base;
		int          per;
		int unsigned pick;
		base = sampled_ticks;
		per  = int'(ticks_per_bit());
		while (sampled_ticks - base < budget) begin
			pick = $urandom_range(0, 99);
			if (p_mode == MODE_SEND) begin
				drive_tick(1'($urandom_range(0, 1)));
			end else if (pick < 65) begin
				// Hold the line high until the frame in progress finishes.
				if (p_mode == MODE_IDLE)
					send_frame(8'($urandom), 1'b1, 1'b1);
				else
					drive_tick(1'b1);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 3 * per))
					drive_tick(1'b1);
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 2 * per))
					drive_tick(1'($urandom_range(0, 1)));
			end else begin
				send_frame(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
			end
		end
	endtask

	// Bring the line logic back to idle, drop valid, and let every queued
	// result drain before registers change.
	task automatic drain_to_idle();
		while (p_mode != MODE_IDLE)
			drive_tick(1'b1);
		in_ch.valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	// Result side: check each transaction against the oldest expectation and
	// stall at random.
	always @(posedge clk) begin : result_check
		result_t want;
		result_t seen;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen = '{out_ch.tx_line, out_ch.byte_done, out_ch.received_byte,
				out_ch.echoing};
			if (tick_results_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t result with none expected: tx %b done %b byte %02h echo %b",
						$time, seen.tx_line, seen.byte_done, seen.received_byte,
						seen.echoing);
			end else begin
				want = tick_results_q.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t result mismatch (expected/actual): tx %b/%b ",
							"done %b/%b byte %02h/%02h echo %b/%b"}, $time,
							want.tx_line, seen.tx_line, want.byte_done, seen.byte_done,
							want.received_byte, seen.received_byte,
							want.echoing, seen.echoing);
				end
			end
		end
		out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		// Drive every input to a known level before the first edge.
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_ch.valid   = 1'b0;
		in_ch.rx_line = 1'b1;
		out_ch.ready  = 1'b0;

		// Model state after reset; the buffer is never read unwritten.
		cfg_shadow.bit_period   = BIT_PERIOD_RST;
		cfg_shadow.batch_length = BATCH_LEN_RST;
		p_mode         = MODE_IDLE;
		p_timer        = 8'd0;
		p_slot         = 4'd0;
		p_shift        = 8'h00;
		p_held         = 5'd0;
		p_sent         = 5'd0;
		p_txd          = 1'b1;
		sampled_ticks  = 0;
		mismatch_count = 0;
		cycle_count    = 0;

		// Sender idles more lightly than the receiver at first.
		send_idle_pct = 37;
		recv_idle_pct = 51;

		// Hold reset, then release it once.
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers must come up at their reset values.
		check_reg(REG_BIT_PERIOD);
		check_reg(REG_BATCH_LEN);

		// Directed rows at one tick per bit and a batch of two.
		program_regs(9'd1, 5'd2);
		for (int r = 0; r < $size(DIRECTED); r++)
			repeat (DIRECTED[r].reps)
				drive_tick(DIRECTED[r].rx, DIRECTED[r].typed, DIRECTED[r].want);
		drain_to_idle();

		// Random phases; swap the idle rates after three, then stop idling.
		for (int ph = 0; ph < $size(PHASES); ph++) begin
			if (ph == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 37;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			program_regs(PHASES[ph].period, PHASES[ph].batch);
			run_phase(int'(PHASES[ph].budget));
			drain_to_idle();
		end

		if (mismatch_count == 0 && tick_results_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/sue_pkg.sv
rtl/core/sue_if.sv
rtl/core/sue_cfg.sv
rtl/core/sue_buf.sv
rtl/core/sue_core.sv
rtl/core/soft_uart_batch_echo.sv
tb/tb.sv
